// ----- rtl/core/cst_pkg.sv -----
package cst_pkg;

  localparam int LEN_W = 5;

  localparam logic [1:0] CMD_TRAIN = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam logic [31:0] BLOOM_MULT = 32'd2654435761;
  localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;
  localparam logic [8:0]  UNIQ_MAX   = 9'd256;

  typedef struct packed {
    logic [1:0]       command;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] query_order;
  } in_t;

  typedef struct packed {
    logic [4:0]  new_pairs;
    logic [4:0]  dropped_updates;
    logic        context_found;
    logic        bloom_hit;
    logic [31:0] symbol_count;
    logic [31:0] context_total;
    logic [8:0]  distinct_followers;
    logic [4:0]  window_fill;
  } out_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [7:0]       next;
    logic [31:0]      freq;
  } pair_meta_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [8:0]       uniq;
    logic [31:0]      total;
  } ctx_meta_t;

endpackage

// ----- rtl/core/context_statistics_trainer.sv -----
// Context statistics trainer: PPM-style context counter over a byte window.
// Channels: in_valid/in_ready/in_data carry one command beat (train, query,
// clear window); out_valid/out_ready/out_data return one result beat per
// command; cfg_valid/cfg_ready/cfg_data write freeze_learning (always ready).
// One item at a time: in_ready is high only while the sequencer is idle.
// A probe visits occupied slots in turn until a match, an empty slot or a
// full pass over the table. A query of order q hashes q window bytes and
// then runs its two probes; a train item with window length L runs L
// suffixes, each with its hash and up to two probes. The cost is set by one
// shared 32-bit multiplier (FNV step, Bloom hash, pair key), one byte per
// hash cycle, and the registered read of each table memory on every probe step.
// Clear and unknown commands go from idle straight to the output state;
// frozen train items likewise.
// After reset a clearing pass empties the slot tables and the Bloom bits;
// no item is accepted meanwhile, configuration writes are taken as ever.
// A finished result waits in the output register while out_ready is low;
// the sequencer holds in its output state until that beat leaves.
module context_statistics_trainer #(
  parameter int MAX_ORDER        = 24,
  parameter int PAIR_CAPACITY    = 65536,
  parameter int PAIR_SLOTS       = 131072,
  parameter int CONTEXT_CAPACITY = 16384,
  parameter int CONTEXT_SLOTS    = 32768,
  parameter int BLOOM_SIZE       = 262144
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cst_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cst_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data
);

  localparam int LW    = cst_pkg::LEN_W;
  localparam int KEY_W = 8 * MAX_ORDER;
  localparam int HI_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int PS_W  = $clog2(PAIR_SLOTS);
  localparam int PC_W  = $clog2(PAIR_CAPACITY);
  localparam int CS_W  = $clog2(CONTEXT_SLOTS);
  localparam int CC_W  = $clog2(CONTEXT_CAPACITY);
  localparam int BL_W  = $clog2(BLOOM_SIZE);
  localparam int CLR_N0 = (PAIR_SLOTS > CONTEXT_SLOTS) ? PAIR_SLOTS : CONTEXT_SLOTS;
  localparam int CLR_N  = (CLR_N0 > BLOOM_SIZE) ? CLR_N0 : BLOOM_SIZE;
  localparam int CLR_W  = $clog2(CLR_N);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_BL1   = 4'd3;
  localparam logic [3:0] S_BL2   = 4'd4;
  localparam logic [3:0] S_BL3   = 4'd5;
  localparam logic [3:0] S_P_RD  = 4'd6;
  localparam logic [3:0] S_P_SL  = 4'd7;
  localparam logic [3:0] S_P_CMP = 4'd8;
  localparam logic [3:0] S_C_RD  = 4'd9;
  localparam logic [3:0] S_C_SL  = 4'd10;
  localparam logic [3:0] S_C_CMP = 4'd11;
  localparam logic [3:0] S_NEXT  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]       state;
  logic [CLR_W-1:0] clr;
  logic             freeze;

  logic [7:0]    hist [MAX_ORDER];
  logic [LW-1:0] len;

  logic [1:0]       cmd;
  logic [7:0]       b;
  logic [LW-1:0]    n;
  logic [LW-1:0]    i;
  logic [31:0]      h;
  logic [31:0]      mh;
  logic [KEY_W-1:0] key;
  logic             bit1;
  logic             is_new;
  logic [PS_W-1:0]  ph;
  logic [PS_W:0]    pcnt;
  logic [CS_W-1:0]  cph;
  logic [CS_W:0]    ccnt;
  logic [PC_W:0]    pu;
  logic [CC_W:0]    cu;

  logic [4:0]  r_newp;
  logic [4:0]  r_drop;
  logic        r_found;
  logic        r_hit;
  logic [31:0] r_scount;
  logic [31:0] r_total;
  logic [8:0]  r_uniq;

  // memories and their registered read data
  logic [PC_W:0]       pslot_mem [PAIR_SLOTS];
  logic [KEY_W-1:0]    pkey_mem  [PAIR_CAPACITY];
  cst_pkg::pair_meta_t pmeta_mem [PAIR_CAPACITY];
  logic [CC_W:0]       cslot_mem [CONTEXT_SLOTS];
  logic [KEY_W-1:0]    ckey_mem  [CONTEXT_CAPACITY];
  cst_pkg::ctx_meta_t  cmeta_mem [CONTEXT_CAPACITY];
  logic                bloom_mem [BLOOM_SIZE];

  logic [PC_W:0]       ps_q;
  logic [KEY_W-1:0]    pk_q;
  cst_pkg::pair_meta_t pm_q;
  logic [CC_W:0]       cs_q;
  logic [KEY_W-1:0]    ck_q;
  cst_pkg::ctx_meta_t  cm_q;
  logic                bl_q;

  // shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mres;

  logic [7:0]      hbyte;
  logic [LW-1:0]   hidx;
  logic            is_train;
  logic            clearing;
  logic [PC_W-1:0] pidx;
  logic [CC_W-1:0] cidx;
  logic            p_empty;
  logic            p_room;
  logic            p_match;
  logic            p_ins;
  logic            p_upd;
  logic            p_last;
  logic            c_empty;
  logic            c_room;
  logic            c_match;
  logic            c_ins;
  logic            c_upd;
  logic            c_last;
  logic            bl_we;
  logic [BL_W-1:0] bl_addr;
  logic            out_load;
  logic [LW-1:0]   len_next;
  logic            suffix_last;

  cst_pkg::pair_meta_t pm_new;
  cst_pkg::pair_meta_t pm_inc;
  cst_pkg::ctx_meta_t  cm_new;
  cst_pkg::ctx_meta_t  cm_inc;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign clearing  = (state == S_CLR);
  assign is_train  = (cmd == cst_pkg::CMD_TRAIN);

  // select the window byte for the current hash step
  always_comb begin
    hidx  = LW'(len - n + i);
    hbyte = hist[hidx[HI_W-1:0]];
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = h ^ {24'd0, hbyte};
    mul_b = cst_pkg::FNV_PRIME;
    case (state)
      S_BL1: begin
        mul_a = h;
        mul_b = cst_pkg::BLOOM_MULT;
      end
      S_BL2: begin
        mul_a = h ^ {24'd0, b};
        mul_b = cst_pkg::FNV_PRIME;
      end
      default: begin
        mul_a = h ^ {24'd0, hbyte};
        mul_b = cst_pkg::FNV_PRIME;
      end
    endcase
  end

  assign mres = 32'(mul_a * mul_b);

  // probe decisions
  always_comb begin
    pidx    = PC_W'(ps_q - 1'b1);
    cidx    = CC_W'(cs_q - 1'b1);
    p_empty = (ps_q == '0);
    c_empty = (cs_q == '0);
    p_room  = (pu < (PC_W+1)'(PAIR_CAPACITY));
    c_room  = (cu < (CC_W+1)'(CONTEXT_CAPACITY));
    p_match = (pm_q.len == n) && (pm_q.next == b) && (pk_q == key);
    c_match = (cm_q.len == n) && (ck_q == key);
    p_last  = ((pcnt + 1'b1) == (PS_W+1)'(PAIR_SLOTS));
    c_last  = ((ccnt + 1'b1) == (CS_W+1)'(CONTEXT_SLOTS));
    p_ins   = (state == S_P_SL) && p_empty && is_train && p_room;
    p_upd   = (state == S_P_CMP) && p_match && is_train;
    c_ins   = (state == S_C_SL) && c_empty && is_train && c_room;
    c_upd   = (state == S_C_CMP) && c_match && is_train;
    bl_we   = is_train && ((state == S_BL1) || (state == S_BL2));
    bl_addr = (state == S_BL1) ? h[BL_W-1:0] : mh[BL_W-1:0];
    suffix_last = (n == len);

    pm_new.len  = n;
    pm_new.next = b;
    pm_new.freq = 32'd1;
    pm_inc      = pm_q;
    if (pm_q.freq != cst_pkg::SAT32) pm_inc.freq = pm_q.freq + 32'd1;

    cm_new.len   = n;
    cm_new.uniq  = {8'd0, is_new};
    cm_new.total = 32'd1;
    cm_inc       = cm_q;
    if (cm_q.total != cst_pkg::SAT32) cm_inc.total = cm_q.total + 32'd1;
    if (is_new && (cm_q.uniq < cst_pkg::UNIQ_MAX)) cm_inc.uniq = cm_q.uniq + 9'd1;
  end

  // window length after the item
  always_comb begin
    len_next = len;
    case (cmd)
      cst_pkg::CMD_TRAIN: if (len < LW'(MAX_ORDER)) len_next = len + 1'b1;
      cst_pkg::CMD_CLEAR: len_next = '0;
      default: len_next = len;
    endcase
  end

  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  // pair slot table
  always_ff @(posedge clk) begin
    if (clearing) begin
      pslot_mem[clr[PS_W-1:0]] <= '0;
    end else if (p_ins) begin
      pslot_mem[ph] <= pu + 1'b1;
    end
    ps_q <= pslot_mem[ph];
  end

  // pair keys and counts
  always_ff @(posedge clk) begin
    if (p_ins) pkey_mem[pu[PC_W-1:0]] <= key;
    pk_q <= pkey_mem[pidx];
  end

  always_ff @(posedge clk) begin
    if (p_ins) begin
      pmeta_mem[pu[PC_W-1:0]] <= pm_new;
    end else if (p_upd) begin
      pmeta_mem[pidx] <= pm_inc;
    end
    pm_q <= pmeta_mem[pidx];
  end

  // context slot table
  always_ff @(posedge clk) begin
    if (clearing) begin
      cslot_mem[clr[CS_W-1:0]] <= '0;
    end else if (c_ins) begin
      cslot_mem[cph] <= cu + 1'b1;
    end
    cs_q <= cslot_mem[cph];
  end

  // context keys and totals
  always_ff @(posedge clk) begin
    if (c_ins) ckey_mem[cu[CC_W-1:0]] <= key;
    ck_q <= ckey_mem[cidx];
  end

  always_ff @(posedge clk) begin
    if (c_ins) begin
      cmeta_mem[cu[CC_W-1:0]] <= cm_new;
    end else if (c_upd) begin
      cmeta_mem[cidx] <= cm_inc;
    end
    cm_q <= cmeta_mem[cidx];
  end

  // Bloom bits
  always_ff @(posedge clk) begin
    if (clearing) begin
      bloom_mem[clr[BL_W-1:0]] <= 1'b0;
    end else if (bl_we) begin
      bloom_mem[bl_addr] <= 1'b1;
    end
    bl_q <= bloom_mem[bl_addr];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      freeze <= 1'b0;
    end else if (cfg_valid) begin
      freeze <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      len       <= '0;
      pu        <= '0;
      cu        <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < MAX_ORDER; k++) hist[k] <= 8'd0;
    end else begin
      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == CLR_W'(CLR_N - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd      <= in_data.command;
            b        <= in_data.data_byte;
            r_newp   <= '0;
            r_drop   <= '0;
            r_found  <= 1'b0;
            r_hit    <= 1'b0;
            r_scount <= '0;
            r_total  <= '0;
            r_uniq   <= '0;
            h        <= cst_pkg::FNV_BASIS;
            i        <= '0;
            key      <= '0;
            is_new   <= 1'b0;
            pcnt     <= '0;
            ccnt     <= '0;
            if (in_data.command == cst_pkg::CMD_TRAIN) begin
              n     <= LW'(1);
              state <= (!freeze && (len != '0)) ? S_HASH : S_OUT;
            end else if (in_data.command == cst_pkg::CMD_QUERY) begin
              n     <= in_data.query_order;
              state <= ((in_data.query_order != '0) && (in_data.query_order <= len)) ?
                       S_HASH : S_OUT;
            end else begin
              state <= S_OUT;
            end
          end
        end
        // hash one byte per cycle and pack the key
        S_HASH: begin
          h <= mres;
          key[8*i[HI_W-1:0] +: 8] <= hbyte;
          i <= i + 1'b1;
          if (i == n - 1'b1) state <= S_BL1;
        end
        S_BL1: begin
          mh    <= mres;
          state <= S_BL2;
        end
        S_BL2: begin
          bit1  <= bl_q;
          ph    <= mres[PS_W-1:0];
          state <= S_BL3;
        end
        S_BL3: begin
          if (!is_train) r_hit <= bit1 & bl_q;
          cph   <= h[CS_W-1:0];
          state <= S_P_RD;
        end
        S_P_RD: state <= S_P_SL;
        S_P_SL: begin
          if (!p_empty) begin
            state <= S_P_CMP;
          end else if (!is_train) begin
            state <= S_C_RD;
          end else if (p_room) begin
            pu     <= pu + 1'b1;
            r_newp <= r_newp + 1'b1;
            is_new <= 1'b1;
            state  <= S_C_RD;
          end else begin
            r_drop <= r_drop + 1'b1;
            state  <= S_NEXT;
          end
        end
        S_P_CMP: begin
          if (p_match) begin
            if (!is_train) r_scount <= pm_q.freq;
            state <= S_C_RD;
          end else if (p_last) begin
            if (is_train) begin
              r_drop <= r_drop + 1'b1;
              state  <= S_NEXT;
            end else begin
              state <= S_C_RD;
            end
          end else begin
            ph    <= ph + 1'b1;
            pcnt  <= pcnt + 1'b1;
            state <= S_P_RD;
          end
        end
        S_C_RD: state <= S_C_SL;
        S_C_SL: begin
          if (!c_empty) begin
            state <= S_C_CMP;
          end else if (!is_train) begin
            state <= S_OUT;
          end else begin
            if (c_room) cu <= cu + 1'b1;
            else r_drop <= r_drop + 1'b1;
            state <= S_NEXT;
          end
        end
        S_C_CMP: begin
          if (c_match) begin
            if (!is_train) begin
              r_found <= 1'b1;
              r_total <= cm_q.total;
              r_uniq  <= cm_q.uniq;
              state   <= S_OUT;
            end else begin
              state <= S_NEXT;
            end
          end else if (c_last) begin
            if (is_train) begin
              r_drop <= r_drop + 1'b1;
              state  <= S_NEXT;
            end else begin
              state <= S_OUT;
            end
          end else begin
            cph   <= cph + 1'b1;
            ccnt  <= ccnt + 1'b1;
            state <= S_C_RD;
          end
        end
        // advance to the next suffix order
        S_NEXT: begin
          if (suffix_last) begin
            state <= S_OUT;
          end else begin
            n      <= n + 1'b1;
            h      <= cst_pkg::FNV_BASIS;
            i      <= '0;
            key    <= '0;
            is_new <= 1'b0;
            pcnt   <= '0;
            ccnt   <= '0;
            state  <= S_HASH;
          end
        end
        // hand off the result beat and update the window
        S_OUT: begin
          if (out_load) begin
            out_valid                   <= 1'b1;
            out_data.new_pairs          <= r_newp;
            out_data.dropped_updates    <= r_drop;
            out_data.context_found      <= r_found;
            out_data.bloom_hit          <= r_hit;
            out_data.symbol_count       <= r_scount;
            out_data.context_total      <= r_total;
            out_data.distinct_followers <= r_uniq;
            out_data.window_fill        <= 5'(len_next);
            len                         <= len_next;
            if (cmd == cst_pkg::CMD_TRAIN) begin
              if (len < LW'(MAX_ORDER)) begin
                hist[len[HI_W-1:0]] <= b;
              end else begin
                for (int k = 0; k < MAX_ORDER - 1; k++) hist[k] <= hist[k+1];
                hist[MAX_ORDER-1] <= b;
              end
            end else if (cmd == cst_pkg::CMD_CLEAR) begin
              for (int k = 0; k < MAX_ORDER; k++) hist[k] <= 8'd0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // no item is taken before the clearing pass has finished
  a_clear_first: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !in_ready)
    else $error("item accepted during clearing pass");

  a_pairs_bound: assert property (@(posedge clk) disable iff (rst)
    pu <= (PC_W+1)'(PAIR_CAPACITY))
    else $error("pair entries beyond capacity");

  a_ctx_bound: assert property (@(posedge clk) disable iff (rst)
    cu <= (CC_W+1)'(CONTEXT_CAPACITY))
    else $error("context entries beyond capacity");

  a_suffix_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> ((r_newp <= 5'(MAX_ORDER)) && (r_drop <= 5'(MAX_ORDER))))
    else $error("more suffix updates than window orders");

  a_window_fill: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_data.window_fill == 5'(len)))
    else $error("reported window length differs from window");

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int WINDOW      = 24;
  localparam int PAIR_CAP    = 65536;
  localparam int PAIR_NSLOT  = 131072;
  localparam int CTX_CAP     = 16384;
  localparam int CTX_NSLOT   = 32768;
  localparam int BLOOM_NBIT  = 262144;
  localparam int STALL_LIMIT = 1000000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  cst_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  cst_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;

  context_statistics_trainer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow state of the trainer
  logic              frozen;
  logic [7:0]        window [WINDOW];
  int unsigned       window_len;
  int unsigned       pair_slot_map [int unsigned];
  logic [191:0]      pair_key [int unsigned];
  logic [4:0]        pair_len [int unsigned];
  logic [7:0]        pair_next [int unsigned];
  logic [31:0]       pair_freq [int unsigned];
  int unsigned       pairs_used;
  int unsigned       ctx_slot_map [int unsigned];
  logic [191:0]      ctx_key [int unsigned];
  logic [4:0]        ctx_len [int unsigned];
  logic [8:0]        ctx_uniq [int unsigned];
  logic [31:0]       ctx_total [int unsigned];
  int unsigned       contexts_used;
  bit                bloom [int unsigned];

  cst_pkg::out_t expected_q [$];
  int   error_count;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   hold_cycles;
  int   stall_count;

  function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[31:0];
  endfunction

  // FNV-1a over window[start +: n]
  function automatic logic [31:0] suffix_hash(int unsigned start, int unsigned n);
    logic [31:0] h;
    h = cst_pkg::FNV_BASIS;
    for (int unsigned i = 0; i < n; i++) begin
      h = mul32(h ^ {24'd0, window[start + i]}, cst_pkg::FNV_PRIME);
    end
    return h;
  endfunction

  function automatic logic [191:0] suffix_key(int unsigned start, int unsigned n);
    logic [191:0] k;
    k = '0;
    for (int unsigned i = 0; i < n; i++) k[8*i +: 8] = window[start + i];
    return k;
  endfunction

  function automatic bit bloom_test(logic [31:0] bitpos);
    int unsigned p;
    p = bitpos & (BLOOM_NBIT - 1);
    return bloom.exists(p);
  endfunction

  // >=0 entry, -1 empty slot found, -2 no room
  function automatic int pair_lookup(logic [191:0] k, int unsigned n, logic [7:0] nxt,
                                     logic [31:0] hkey, output int unsigned slot);
    int unsigned h;
    int unsigned idx;
    h = hkey & (PAIR_NSLOT - 1);
    slot = 0;
    for (int unsigned i = 0; i < PAIR_NSLOT; i++) begin
      if (!pair_slot_map.exists(h)) begin
        slot = h;
        return -1;
      end
      idx = (pair_slot_map[h] - 1) % PAIR_CAP;
      if (pair_len[idx] == n && pair_next[idx] == nxt && pair_key[idx] == k) return idx;
      h = (h + 1) & (PAIR_NSLOT - 1);
    end
    return -2;
  endfunction

  function automatic int ctx_lookup(logic [191:0] k, int unsigned n, logic [31:0] hkey,
                                    output int unsigned slot);
    int unsigned h;
    int unsigned idx;
    h = hkey & (CTX_NSLOT - 1);
    slot = 0;
    for (int unsigned i = 0; i < CTX_NSLOT; i++) begin
      if (!ctx_slot_map.exists(h)) begin
        slot = h;
        return -1;
      end
      idx = (ctx_slot_map[h] - 1) % CTX_CAP;
      if (ctx_len[idx] == n && ctx_key[idx] == k) return idx;
      h = (h + 1) & (CTX_NSLOT - 1);
    end
    return -2;
  endfunction

  // Count the byte under every suffix of the window
  function automatic void train_suffixes(logic [7:0] b, output int unsigned created,
                                         output int unsigned lost);
    logic [31:0]  ch;
    logic [191:0] k;
    int unsigned  slot;
    int           r;
    bit           fresh;
    created = 0;
    lost = 0;
    for (int unsigned n = 1; n <= window_len; n++) begin
      ch = suffix_hash(window_len - n, n);
      k = suffix_key(window_len - n, n);
      bloom[ch & (BLOOM_NBIT - 1)] = 1'b1;
      bloom[mul32(ch, cst_pkg::BLOOM_MULT) & (BLOOM_NBIT - 1)] = 1'b1;
      fresh = 0;
      r = pair_lookup(k, n, b, mul32(ch ^ {24'd0, b}, cst_pkg::FNV_PRIME), slot);
      if (r >= 0) begin
        if (pair_freq[r] != cst_pkg::SAT32) pair_freq[r]++;
      end else if (r == -1 && pairs_used < PAIR_CAP) begin
        pair_key[pairs_used] = k;
        pair_len[pairs_used] = n;
        pair_next[pairs_used] = b;
        pair_freq[pairs_used] = 32'd1;
        pair_slot_map[slot] = pairs_used + 1;
        pairs_used++;
        fresh = 1;
        created++;
      end else begin
        lost++;
        continue;
      end
      r = ctx_lookup(k, n, ch, slot);
      if (r == -1 && contexts_used < CTX_CAP) begin
        ctx_key[contexts_used] = k;
        ctx_len[contexts_used] = n;
        ctx_uniq[contexts_used] = '0;
        ctx_total[contexts_used] = '0;
        ctx_slot_map[slot] = contexts_used + 1;
        r = contexts_used;
        contexts_used++;
      end
      if (r < 0) begin
        lost++;
        continue;
      end
      if (ctx_total[r] != cst_pkg::SAT32) ctx_total[r]++;
      if (fresh && ctx_uniq[r] < cst_pkg::UNIQ_MAX) ctx_uniq[r]++;
    end
  endfunction

  // Apply one accepted beat to the shadow state, return its result
  function automatic cst_pkg::out_t predict_result(cst_pkg::in_t x);
    cst_pkg::out_t o;
    int unsigned created;
    int unsigned lost;
    int unsigned q;
    int unsigned slot;
    int          r;
    logic [31:0] ch;
    logic [191:0] k;
    o = '0;
    q = x.query_order;
    if (x.command == cst_pkg::CMD_TRAIN) begin
      if (!frozen) begin
        train_suffixes(x.data_byte, created, lost);
        o.new_pairs = created[4:0];
        o.dropped_updates = lost[4:0];
      end
      if (window_len < WINDOW) begin
        window[window_len] = x.data_byte;
        window_len++;
      end else begin
        for (int i = 0; i < WINDOW - 1; i++) window[i] = window[i + 1];
        window[WINDOW - 1] = x.data_byte;
      end
    end else if (x.command == cst_pkg::CMD_QUERY) begin
      if (q >= 1 && q <= window_len) begin
        ch = suffix_hash(window_len - q, q);
        k = suffix_key(window_len - q, q);
        o.bloom_hit = bloom_test(ch) && bloom_test(mul32(ch, cst_pkg::BLOOM_MULT));
        r = ctx_lookup(k, q, ch, slot);
        if (r >= 0) begin
          o.context_found = 1'b1;
          o.context_total = ctx_total[r];
          o.distinct_followers = ctx_uniq[r];
        end
        r = pair_lookup(k, q, x.data_byte,
                        mul32(ch ^ {24'd0, x.data_byte}, cst_pkg::FNV_PRIME), slot);
        if (r >= 0) o.symbol_count = pair_freq[r];
      end
    end else if (x.command == cst_pkg::CMD_CLEAR) begin
      for (int i = 0; i < WINDOW; i++) window[i] = '0;
      window_len = 0;
    end
    o.window_fill = window_len[4:0];
    return o;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result checker and receiver stall control
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected result beat: %p", out_data);
        end else begin
          cst_pkg::out_t e;
          e = expected_q.pop_front();
          if (out_data.new_pairs !== e.new_pairs ||
              out_data.dropped_updates !== e.dropped_updates ||
              out_data.context_found !== e.context_found ||
              out_data.bloom_hit !== e.bloom_hit ||
              out_data.symbol_count !== e.symbol_count ||
              out_data.context_total !== e.context_total ||
              out_data.distinct_followers !== e.distinct_followers ||
              out_data.window_fill !== e.window_fill) begin
            error_count++;
            if (error_count <= 10)
              $display("result mismatch: expected %p actual %p", e, out_data);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic send_item(cst_pkg::in_t x);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_result(x));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_freeze(logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    frozen = v;
  endtask

  function automatic cst_pkg::in_t make_item(logic [1:0] cmd, logic [7:0] b, logic [4:0] q);
    cst_pkg::in_t x;
    x.command = cmd;
    x.data_byte = b;
    x.query_order = q;
    return x;
  endfunction

  // Mostly short alphabets so contexts repeat, plus noise
  function automatic cst_pkg::in_t random_item();
    cst_pkg::in_t x;
    int  r;
    r = $urandom_range(99);
    x.data_byte = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    x.query_order = 5'($urandom);
    if (r < 58) begin
      x.command = cst_pkg::CMD_TRAIN;
    end else if (r < 92) begin
      x.command = cst_pkg::CMD_QUERY;
      if (window_len > 0 && $urandom_range(9) != 0)
        x.query_order = 5'($urandom_range(1, window_len));
    end else if (r < 96) begin
      x.command = cst_pkg::CMD_CLEAR;
    end else begin
      x.command = CMD_UNKNOWN;
    end
    return x;
  endfunction

  task automatic test_directed;
    send_item(make_item(cst_pkg::CMD_QUERY, 8'h00, 5'd1));
    send_item(make_item(cst_pkg::CMD_TRAIN, 8'h00, 5'd31));
    send_item(make_item(cst_pkg::CMD_TRAIN, 8'hFF, 5'd0));
    send_item(make_item(cst_pkg::CMD_QUERY, 8'hFF, 5'd1));
    send_item(make_item(cst_pkg::CMD_QUERY, 8'hFF, 5'd0));
    send_item(make_item(cst_pkg::CMD_QUERY, 8'hFF, 5'd3));
    send_item(make_item(CMD_UNKNOWN, 8'hA5, 5'd31));
    send_item(make_item(cst_pkg::CMD_CLEAR, 8'h5A, 5'd16));
    for (int i = 0; i < 13; i++)
      send_item(make_item(cst_pkg::CMD_TRAIN, 8'(i % 2 ? 255 : 0), 5'd0));
    send_item(make_item(cst_pkg::CMD_QUERY, 8'h00, 5'd12));
    send_item(make_item(cst_pkg::CMD_QUERY, 8'hFF, 5'd2));
    send_item(make_item(cst_pkg::CMD_QUERY, 8'h00, 5'd31));
    drain();
  endtask

  // Fill the window to its full length and run shifted suffixes
  task automatic test_full_window;
    for (int i = 0; i < 26; i++)
      send_item(make_item(cst_pkg::CMD_TRAIN, 8'(i % 3), 5'($urandom)));
    send_item(make_item(cst_pkg::CMD_QUERY, 8'd2, 5'd24));
    send_item(make_item(cst_pkg::CMD_QUERY, 8'd1, 5'd25));
    drain();
  endtask

  task automatic test_frozen;
    write_freeze(1'b1);
    for (int i = 0; i < 10; i++) send_item(random_item());
    send_item(make_item(cst_pkg::CMD_TRAIN, 8'd7, 5'd1));
    drain();
    write_freeze(1'b0);
  endtask

  task automatic test_random(int n, int src_pct, int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int i = 0; i < n; i++) send_item(random_item());
    drain();
  endtask

  // Long receiver hold-off while items keep coming, then a full pause
  task automatic test_backpressure;
    hold_cycles = 3000;
    for (int i = 0; i < 8; i++) send_item(random_item());
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    @(posedge clk);
    for (int i = 0; i < 8; i++) send_item(random_item());
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= 1'b0;
    frozen = 1'b0;
    window_len = 0;
    for (int i = 0; i < WINDOW; i++) window[i] = '0;
    pairs_used = 0;
    contexts_used = 0;
    error_count = 0;
    hold_cycles = 0;
    stall_count = 0;
    src_idle_pct = 27;
    snk_idle_pct = 56;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_freeze(1'b0);
    test_directed();
    test_full_window();
    test_frozen();
    test_random(170, 27, 56);
    test_backpressure();
    write_freeze(1'b1);
    test_random(20, 56, 27);
    write_freeze(1'b0);
    test_random(150, 56, 27);
    test_random(150, 0, 0);
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
